// ===== design/tdcps_pkg.sv =====
// shared types and constants for the tdc event position sums block
// no dependencies; used by tdcps_alu and tdc_event_position_sums
`default_nettype none

package tdcps_pkg;

  // width of the shared add/subtract unit, holds any sum or difference of times
  localparam int ALU_W = 24;

  // widths fixed by the interface
  localparam int CHAN_W      = 6;
  localparam int PORT_TIME_W = 21;
  localparam int HIT_W       = 12;
  localparam int SUM_W       = 23;
  localparam int DIFF_W      = 22;
  localparam int PAT_W       = 9;
  localparam int MULT_W      = 4;

  localparam logic [HIT_W-1:0]  HIT_MAX    = 12'hFFF;
  localparam logic [CHAN_W-1:0] TRIG_RESET = 6'd7;

  // fixed channel map
  localparam int ANODE1_BASE  = 0;
  localparam int ANODE2_BASE  = 3;
  localparam int ANODE_LAST   = 5;
  localparam int CATHODE_BASE = 6;

  // record kinds
  typedef logic [2:0] rec_t;
  localparam rec_t REC_SUMMARY = 3'd0;
  localparam rec_t REC_X1      = 3'd1;

  typedef enum logic {
    ALU_ADD,
    ALU_SUB
  } alu_op_t;

  typedef struct packed {
    alu_op_t                 op;
    logic signed [ALU_W-1:0] a;
    logic signed [ALU_W-1:0] b;
  } alu_req_t;

endpackage

`default_nettype wire

// ===== design/tdc_event_position_sums.sv =====
// steps: a leading hit in channel range is accepted, then updates the store; other hits are only accepted
// after the last hit: summary record after the store update (or directly if it skips the store),
//   then an anode scan and a read, sum, subtract, difference and emit pass per cathode pair, each
//   record waiting for a free output; steps share the single time-store read port and add/subtract unit
// reset: synchronous rst_n clears presence bits, hit count, trigger latch, output valid,
//   trigger channel back to 7, time store not cleared; depends on tdcps_pkg, tdcps_alu
`default_nettype none

module tdc_event_position_sums #(
  parameter int CHANNELS  = 64,
  parameter int TIME_BITS = 21
) (
  input  wire logic        clk,
  input  wire logic        rst_n,
  // configuration: trigger channel
  input  wire logic        cfg_we,
  input  wire logic [5:0]  cfg_wdata,
  // hit stream
  input  wire logic        in_tvalid,
  output logic             in_tready,
  input  wire logic [31:0] in_tdata,   // hit_channel[5:0], hit_time[26:6], zero pad
  input  wire logic        in_tuser,   // trailing_edge
  input  wire logic        in_tlast,   // event_end
  // record stream
  output logic             out_tvalid,
  input  wire logic        out_tready,
  output logic [95:0]      out_tdata,  // pathway_pattern[8:0], multiplicity[12:9],
                                       // hit_total[24:13], trigger_time[45:25],
                                       // pair_valid[46], time_sum[69:47],
                                       // time_diff[91:70], zero pad
  output logic [2:0]       out_tuser,  // record
  output logic             out_tlast   // last_result
);

  // internal time width: the port carries 21 bits, only the low TIME_BITS are used
  localparam int TW = (TIME_BITS < tdcps_pkg::PORT_TIME_W) ? TIME_BITS
                                                           : tdcps_pkg::PORT_TIME_W;
  localparam int CW = $clog2(CHANNELS);
  localparam int ALU_W = tdcps_pkg::ALU_W;

  typedef enum logic [3:0] {
    S_IDLE,     // ready for a hit
    S_UPD,      // compare against stored earliest time and write back
    S_SUMMARY,  // present the summary record
    S_ARD,      // address one anode channel
    S_ACMP,     // fold anode time into its group minimum
    S_CRD0,     // address first cathode of the pair
    S_CRD1,     // latch first cathode, address second
    S_CSUM,     // sum of both cathode times
    S_CSUB,     // minus twice the anode time
    S_CDIFF,    // cathode difference
    S_CEMIT     // present the pair record
  } state_t;

  // control registers
  state_t                     state_r, state_nxt;
  logic [2:0]                 idx_r, idx_nxt;
  logic [1:0]                 pair_r, pair_nxt;
  logic [5:0]                 trig_ch_r, trig_ch_nxt;
  logic [tdcps_pkg::HIT_W-1:0] hit_cnt_r, hit_cnt_nxt;
  logic                       trig_seen_r, trig_seen_nxt;
  logic [CHANNELS-1:0]        seen_r, seen_nxt;
  logic                       have1_r, have1_nxt;
  logic                       have2_r, have2_nxt;
  logic                       out_tvalid_r, out_tvalid_nxt;

  // payload registers
  logic [TW-1:0]              trig_val_r, trig_val_nxt;
  logic [CW-1:0]              hit_ch_r, hit_ch_nxt;
  logic [TW-1:0]              hit_t_r, hit_t_nxt;
  logic                       last_r, last_nxt;
  logic [TW-1:0]              best1_r, best1_nxt;
  logic [TW-1:0]              best2_r, best2_nxt;
  logic [TW-1:0]              c0_r, c0_nxt;
  logic [TW-1:0]              c1_r, c1_nxt;
  logic signed [ALU_W-1:0]    acc_r, acc_nxt;
  logic signed [ALU_W-1:0]    diff_r, diff_nxt;
  logic [95:0]                out_tdata_r, out_tdata_nxt;
  tdcps_pkg::rec_t            out_tuser_r, out_tuser_nxt;
  logic                       out_tlast_r, out_tlast_nxt;

  // earliest-time store, one write and one registered read per cycle
  logic [TW-1:0]              mem [CHANNELS];
  logic [TW-1:0]              rd_data_r;
  logic [CW-1:0]              raddr;
  logic                       mem_we;

  // shared arithmetic
  tdcps_pkg::alu_req_t        alu_req;
  logic signed [ALU_W-1:0]    alu_res;

  // input fields
  logic [5:0]                 in_chan;
  logic [TW-1:0]              in_time;
  logic                       in_acc;
  logic                       in_range;

  // event summary derived from presence bits
  logic [tdcps_pkg::PAT_W-1:0]  pattern;
  logic [tdcps_pkg::MULT_W-1:0] mult;
  logic [CW-1:0]                cath0;
  logic [CW-1:0]                cath1;
  logic                         out_free;
  logic                         acmp_g2;
  logic                         acmp_take;
  logic [TW-1:0]                anode;
  logic [tdcps_pkg::PORT_TIME_W-1:0] trig_out;

  tdcps_alu u_alu (
    .req (alu_req),
    .res (alu_res)
  );

  assign in_chan  = in_tdata[5:0];
  assign in_time  = in_tdata[6 +: TW];
  assign in_tready = (state_r == S_IDLE);
  assign in_acc   = in_tvalid && in_tready;
  assign in_range = ({1'b0, in_chan} < 7'(CHANNELS));

  assign out_free = !out_tvalid_r || out_tready;

  // anode a of group 1 with anode b of group 2
  always_comb begin
    for (int a = 0; a < 3; a++) begin
      for (int b = 0; b < 3; b++) begin
        pattern[3*a+b] = seen_r[tdcps_pkg::ANODE1_BASE + a] &&
                         seen_r[tdcps_pkg::ANODE2_BASE + b];
      end
    end
  end
  assign mult = tdcps_pkg::MULT_W'($countones(pattern));

  assign cath0 = CW'(tdcps_pkg::CATHODE_BASE) + CW'({pair_r, 1'b0});
  assign cath1 = cath0 + CW'(1);
  assign anode = pair_r[1] ? best2_r : best1_r;
  assign trig_out = trig_seen_r ? tdcps_pkg::PORT_TIME_W'(trig_val_r)
                                : '0;

  assign acmp_g2   = (idx_r >= 3'(tdcps_pkg::ANODE2_BASE));
  assign acmp_take = seen_r[CW'(idx_r)] &&
                     (!(acmp_g2 ? have2_r : have1_r) || alu_res[ALU_W-1]);

  // operand select for the shared unit, from registered state only
  always_comb begin
    alu_req.op = tdcps_pkg::ALU_SUB;
    alu_req.a  = ALU_W'(hit_t_r);
    alu_req.b  = ALU_W'(rd_data_r);
    case (state_r)
      S_ACMP: begin
        alu_req.a = ALU_W'(rd_data_r);
        alu_req.b = ALU_W'(acmp_g2 ? best2_r : best1_r);
      end
      S_CSUM: begin
        alu_req.op = tdcps_pkg::ALU_ADD;
        alu_req.a  = ALU_W'(c0_r);
        alu_req.b  = ALU_W'(rd_data_r);
      end
      S_CSUB: begin
        alu_req.a = acc_r;
        alu_req.b = ALU_W'({anode, 1'b0});
      end
      S_CDIFF: begin
        // x pairs: second minus first; y pairs: first minus second
        alu_req.a = pair_r[0] ? ALU_W'(c0_r) : ALU_W'(c1_r);
        alu_req.b = pair_r[0] ? ALU_W'(c1_r) : ALU_W'(c0_r);
      end
      default: begin
      end
    endcase
  end

  // sequencer
  always_comb begin
    state_nxt      = state_r;
    idx_nxt        = idx_r;
    pair_nxt       = pair_r;
    trig_ch_nxt    = trig_ch_r;
    hit_cnt_nxt    = hit_cnt_r;
    trig_seen_nxt  = trig_seen_r;
    seen_nxt       = seen_r;
    have1_nxt      = have1_r;
    have2_nxt      = have2_r;
    out_tvalid_nxt = out_tvalid_r;
    trig_val_nxt   = trig_val_r;
    hit_ch_nxt     = hit_ch_r;
    hit_t_nxt      = hit_t_r;
    last_nxt       = last_r;
    best1_nxt      = best1_r;
    best2_nxt      = best2_r;
    c0_nxt         = c0_r;
    c1_nxt         = c1_r;
    acc_nxt        = acc_r;
    diff_nxt       = diff_r;
    out_tdata_nxt  = out_tdata_r;
    out_tuser_nxt  = out_tuser_r;
    out_tlast_nxt  = out_tlast_r;
    raddr          = in_chan[CW-1:0];
    mem_we         = 1'b0;

    if (cfg_we) begin
      trig_ch_nxt = cfg_wdata;
    end
    if (out_tvalid_r && out_tready) begin
      out_tvalid_nxt = 1'b0;
    end

    case (state_r)
      S_IDLE: begin
        if (in_acc) begin
          hit_ch_nxt = in_chan[CW-1:0];
          hit_t_nxt  = in_time;
          last_nxt   = in_tlast;
          if (!in_tuser) begin
            if (hit_cnt_r != tdcps_pkg::HIT_MAX) begin
              hit_cnt_nxt = hit_cnt_r + tdcps_pkg::HIT_W'(1);
            end
            if (in_chan == trig_ch_r && !trig_seen_r) begin
              trig_seen_nxt = 1'b1;
              trig_val_nxt  = in_time;
            end
          end
          if (!in_tuser && in_range) begin
            state_nxt = S_UPD;
          end else if (in_tlast) begin
            state_nxt = S_SUMMARY;
          end
        end
      end
      S_UPD: begin
        // keep the smaller time; a first hit always writes
        mem_we = !seen_r[hit_ch_r] || alu_res[ALU_W-1];
        seen_nxt[hit_ch_r] = 1'b1;
        state_nxt = last_r ? S_SUMMARY : S_IDLE;
      end
      S_SUMMARY: begin
        if (out_free) begin
          out_tvalid_nxt = 1'b1;
          out_tuser_nxt  = tdcps_pkg::REC_SUMMARY;
          out_tlast_nxt  = 1'b0;
          out_tdata_nxt  = {4'b0, 22'b0, 23'b0, 1'b0, trig_out, hit_cnt_r, mult, pattern};
          idx_nxt        = 3'(tdcps_pkg::ANODE1_BASE);
          have1_nxt      = 1'b0;
          have2_nxt      = 1'b0;
          state_nxt      = S_ARD;
        end
      end
      S_ARD: begin
        raddr     = CW'(idx_r);
        state_nxt = S_ACMP;
      end
      S_ACMP: begin
        if (acmp_take) begin
          if (acmp_g2) begin
            best2_nxt = rd_data_r;
            have2_nxt = 1'b1;
          end else begin
            best1_nxt = rd_data_r;
            have1_nxt = 1'b1;
          end
        end
        if (idx_r == 3'(tdcps_pkg::ANODE_LAST)) begin
          pair_nxt  = 2'd0;
          state_nxt = S_CRD0;
        end else begin
          idx_nxt   = idx_r + 3'd1;
          state_nxt = S_ARD;
        end
      end
      S_CRD0: begin
        raddr     = cath0;
        state_nxt = S_CRD1;
      end
      S_CRD1: begin
        c0_nxt    = rd_data_r;
        raddr     = cath1;
        state_nxt = S_CSUM;
      end
      S_CSUM: begin
        c1_nxt    = rd_data_r;
        acc_nxt   = alu_res;
        state_nxt = S_CSUB;
      end
      S_CSUB: begin
        acc_nxt   = alu_res;
        state_nxt = S_CDIFF;
      end
      S_CDIFF: begin
        diff_nxt  = alu_res;
        state_nxt = S_CEMIT;
      end
      S_CEMIT: begin
        if (out_free) begin
          out_tvalid_nxt = 1'b1;
          out_tuser_nxt  = tdcps_pkg::REC_X1 + tdcps_pkg::rec_t'(pair_r);
          out_tlast_nxt  = (pair_r == 2'd3);
          if (mult != '0 && seen_r[cath0] && seen_r[cath1]) begin
            out_tdata_nxt = {4'b0, diff_r[tdcps_pkg::DIFF_W-1:0],
                             acc_r[tdcps_pkg::SUM_W-1:0], 1'b1, 21'b0, 12'b0, 4'b0, 9'b0};
          end else begin
            out_tdata_nxt = '0;
          end
          if (pair_r == 2'd3) begin
            // event done, clear event state
            seen_nxt      = '0;
            hit_cnt_nxt   = '0;
            trig_seen_nxt = 1'b0;
            trig_val_nxt  = '0;
            state_nxt     = S_IDLE;
          end else begin
            pair_nxt  = pair_r + 2'd1;
            state_nxt = S_CRD0;
          end
        end
      end
      default: begin
        state_nxt = S_IDLE;
      end
    endcase
  end

  // state and registered outputs
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r      <= S_IDLE;
      idx_r        <= '0;
      pair_r       <= '0;
      trig_ch_r    <= tdcps_pkg::TRIG_RESET;
      hit_cnt_r    <= '0;
      trig_seen_r  <= 1'b0;
      seen_r       <= '0;
      have1_r      <= 1'b0;
      have2_r      <= 1'b0;
      out_tvalid_r <= 1'b0;
    end else begin
      state_r      <= state_nxt;
      idx_r        <= idx_nxt;
      pair_r       <= pair_nxt;
      trig_ch_r    <= trig_ch_nxt;
      hit_cnt_r    <= hit_cnt_nxt;
      trig_seen_r  <= trig_seen_nxt;
      seen_r       <= seen_nxt;
      have1_r      <= have1_nxt;
      have2_r      <= have2_nxt;
      out_tvalid_r <= out_tvalid_nxt;
    end
  end

  // payload, no reset needed
  always_ff @(posedge clk) begin
    trig_val_r  <= trig_val_nxt;
    hit_ch_r    <= hit_ch_nxt;
    hit_t_r     <= hit_t_nxt;
    last_r      <= last_nxt;
    best1_r     <= best1_nxt;
    best2_r     <= best2_nxt;
    c0_r        <= c0_nxt;
    c1_r        <= c1_nxt;
    acc_r       <= acc_nxt;
    diff_r      <= diff_nxt;
    out_tdata_r <= out_tdata_nxt;
    out_tuser_r <= out_tuser_nxt;
    out_tlast_r <= out_tlast_nxt;
  end

  // time store
  always_ff @(posedge clk) begin
    if (mem_we) begin
      mem[hit_ch_r] <= hit_t_r;
    end
    rd_data_r <= mem[raddr];
  end

  assign out_tvalid = out_tvalid_r;
  assign out_tdata  = out_tdata_r;
  assign out_tuser  = out_tuser_r;
  assign out_tlast  = out_tlast_r;

endmodule

`default_nettype wire

// ===== design/tdcps_alu.sv =====
// shared add/subtract unit for time compares, sums and differences
// depends on tdcps_pkg
`default_nettype none

module tdcps_alu (
  input  tdcps_pkg::alu_req_t                 req,
  output logic signed [tdcps_pkg::ALU_W-1:0]  res
);

  always_comb begin
    case (req.op)
      tdcps_pkg::ALU_ADD: res = req.a + req.b;
      tdcps_pkg::ALU_SUB: res = req.a - req.b;
      default:            res = req.a - req.b;
    endcase
  end

endmodule

`default_nettype wire
